/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, switched off while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/hsfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_pkg
// shared types and constants of the haptic sample queue to rumble block
// ----------------------------------------------------------------------------
package hsfr_pkg;

  // default sizes
  localparam int BUFFER_DEPTH_DEF = 4096;
  localparam int CHUNK_LEN_DEF    = 30;

  // field widths
  localparam int FUNC_W      = 2;
  localparam int SAMPLE_W    = 8;
  localparam int LIMIT_W     = 13;
  localparam int INTENSITY_W = 16;
  localparam int TAKEN_W     = 7;
  localparam int TOTAL_W     = 32;

  // queue limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd3000;

  // sample value that means silence
  localparam logic [SAMPLE_W-1:0] SILENCE = 8'd128;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUMP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd3;

  // entries in the command queue between front and engine
  localparam int CMD_DEPTH = 2;

  // decoded command
  typedef struct packed {
    logic                push;
    logic                pump;
    logic                clr_queue;
    logic                clr_total;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

endpackage

/* design/hsfr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_front
// accepts input beats, decodes the function code and queues the commands
// ----------------------------------------------------------------------------
module hsfr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsfr_pkg::FUNC_W-1:0]   func,
  input  logic [hsfr_pkg::SAMPLE_W-1:0] sample,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output hsfr_pkg::cmd_t                cmd
);

  localparam int QD  = hsfr_pkg::CMD_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  hsfr_pkg::cmd_t   queue [QD];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  hsfr_pkg::cmd_t   decoded;
  logic             push_en;
  logic             pop_en;

  // decode of the incoming beat
  always_comb begin
    decoded.push      = (func == hsfr_pkg::FUNC_PUSH);
    decoded.pump      = (func == hsfr_pkg::FUNC_PUMP);
    decoded.clr_queue = (func == hsfr_pkg::FUNC_STOP) || (func == hsfr_pkg::FUNC_RESET);
    decoded.clr_total = (func == hsfr_pkg::FUNC_RESET);
    decoded.sample    = sample;
  end

  // handshakes
  assign in_ready  = (count != QCW'(QD));
  assign cmd_valid = (count != '0);
  assign push_en   = in_valid && in_ready;
  assign pop_en    = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // command storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      queue[wr_ptr] <= decoded;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= (wr_ptr == QAW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_en) begin
        rd_ptr <= (rd_ptr == QAW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_en && !pop_en) begin
        count <= count + 1'b1;
      end else if (pop_en && !push_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/hsfr_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_engine
// sample store, queue pointers, chunk reader, scaler and result register
// ----------------------------------------------------------------------------
module hsfr_engine #(
  parameter int BUFFER_DEPTH = hsfr_pkg::BUFFER_DEPTH_DEF,
  parameter int CHUNK_LEN    = hsfr_pkg::CHUNK_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hsfr_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  hsfr_pkg::cmd_t                   cmd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hsfr_pkg::INTENSITY_W-1:0] intensity,
  output logic [hsfr_pkg::TAKEN_W-1:0]     samples_taken,
  output logic [hsfr_pkg::TOTAL_W-1:0]     total_played
);

  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int FW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CW   = (FW > hsfr_pkg::LIMIT_W) ? FW : hsfr_pkg::LIMIT_W;
  localparam int TW   = $clog2(CHUNK_LEN + 1);
  localparam int QW   = hsfr_pkg::INTENSITY_W;
  localparam int DIV_VAL = CHUNK_LEN * 128;
  localparam int SUMW = $clog2(DIV_VAL + 1);

  // scaled reciprocal of the chunk full scale; 2^KSH above DIV_VAL squared
  // keeps the floor exact for every sum up to DIV_VAL
  localparam int              KSH        = 2 * SUMW;
  localparam longint unsigned FULL_SCALE = 64'hFFFF;
  localparam longint unsigned RECIP      =
    ((FULL_SCALE << KSH) + 64'(DIV_VAL) - 64'd1) / 64'(DIV_VAL);
  localparam int              RW         = $clog2(RECIP + 64'd1);
  localparam int              PW         = SUMW + RW;
  localparam logic [RW-1:0]   RECIP_C    = RW'(RECIP);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUMP  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [hsfr_pkg::SAMPLE_W-1:0] store [BUFFER_DEPTH];
  logic [hsfr_pkg::SAMPLE_W-1:0] rd_data;
  logic [2:0]                    state;
  logic [AW-1:0]                 rp;
  logic [AW-1:0]                 wp;
  logic [FW-1:0]                 fill;
  logic [hsfr_pkg::LIMIT_W-1:0]  buffer_limit;
  logic [hsfr_pkg::TOTAL_W-1:0]  played;
  logic [TW-1:0]                 cnt;
  logic                          rd_pending;
  logic [SUMW-1:0]               sum;
  logic [QW-1:0]                 quo;

  logic [CW-1:0]                 lim_wide;
  logic [CW-1:0]                 lim_eff;
  logic [FW-1:0]                 lim;
  logic                          over;
  logic [FW-1:0]                 drop;
  logic [FW:0]                   rp_sum;
  logic [AW-1:0]                 rp_drop;
  logic [FW-1:0]                 fill_push;
  logic [AW-1:0]                 rp_inc;
  logic [AW-1:0]                 wp_inc;
  logic                          mem_we;
  logic [hsfr_pkg::SAMPLE_W-1:0] dev;
  logic [PW-1:0]                 prod;

  // effective queue limit, clamped to one and to the store depth
  always_comb begin
    lim_wide = CW'(buffer_limit);
    if (lim_wide == '0) begin
      lim_eff = CW'(1);
    end else if (lim_wide > CW'(BUFFER_DEPTH)) begin
      lim_eff = CW'(BUFFER_DEPTH);
    end else begin
      lim_eff = lim_wide;
    end
    lim = lim_eff[FW-1:0];
  end

  // push into a full queue drops the oldest samples first
  always_comb begin
    over      = (fill >= lim);
    drop      = fill - lim + FW'(1);
    rp_sum    = (FW + 1)'(rp) + (FW + 1)'(drop);
    if (!over) begin
      rp_drop = rp;
    end else if (rp_sum >= (FW + 1)'(BUFFER_DEPTH)) begin
      rp_drop = AW'(rp_sum - (FW + 1)'(BUFFER_DEPTH));
    end else begin
      rp_drop = AW'(rp_sum);
    end
    fill_push = over ? lim : fill + 1'b1;
  end

  // circular pointer steps
  assign rp_inc = (rp == AW'(BUFFER_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign wp_inc = (wp == AW'(BUFFER_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign mem_we = (state == ST_IDLE) && cmd_valid && cmd.push;
  assign cmd_ready = (state == ST_IDLE);

  // deviation from silence of the sample just read
  assign dev = (rd_data >= hsfr_pkg::SILENCE) ? rd_data - hsfr_pkg::SILENCE
                                              : hsfr_pkg::SILENCE - rd_data;

  // sum times full scale over chunk scale, as one constant multiply
  assign prod = PW'(sum) * PW'(RECIP_C);

  // sample store, one write and one read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wp] <= cmd.sample;
    end
    rd_data <= store[rp];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rp           <= '0;
      wp           <= '0;
      fill         <= '0;
      played       <= '0;
      buffer_limit <= hsfr_pkg::LIMIT_RESET;
      out_valid    <= 1'b0;
      rd_pending   <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_limit <= cfg_data;
      end
      // result beat taken, unless the next one replaces it right away
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      if (state != ST_PUMP) begin
        rd_pending <= 1'b0;
      end
      if (rd_pending) begin
        sum <= sum + SUMW'(dev);
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.push) begin
              wp   <= wp_inc;
              rp   <= rp_drop;
              fill <= fill_push;
            end else if (cmd.pump) begin
              cnt   <= '0;
              sum   <= '0;
              state <= ST_PUMP;
            end else begin
              rp   <= '0;
              wp   <= '0;
              fill <= '0;
              if (cmd.clr_total) begin
                played <= '0;
              end
            end
          end
        end
        ST_PUMP: begin
          if (cnt == TW'(CHUNK_LEN) || fill == '0) begin
            rd_pending <= 1'b0;
            state      <= ST_DRAIN;
          end else begin
            rd_pending <= 1'b1;
            rp         <= rp_inc;
            fill       <= fill - 1'b1;
            cnt        <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          // last read was summed on the way in, so the scaler can run
          played <= played + hsfr_pkg::TOTAL_W'(cnt);
          quo    <= prod[KSH +: QW];
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            intensity     <= quo;
            samples_taken <= hsfr_pkg::TAKEN_W'(cnt);
            total_played  <= played;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/haptic_sample_fifo_to_rumble.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_sample_fifo_to_rumble
// queues haptic samples and turns chunks of them into rumble intensity
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with func and sample; a beat is taken when
//   both are high. push, stop and reset produce no result beat.
// output channel: out_valid/out_ready with intensity, samples_taken and
//   total_played, one beat per pump.
// configuration: cfg_we writes cfg_data into the queue limit register.
// a two-entry command queue sits in front of the engine, so input beats are
//   taken back to back while it has room.
// push, stop and reset are each handled in the idle state of the engine; they
//   pass through the command queue register before they land.
// a pump holds the engine through its steps in order: a start in the idle
//   state, one store read per sample in the pump state, a last pump step that
//   sees the end and finishes the sum, a drain step that scales by a constant
//   reciprocal and a done step that loads the result register.
// a stalled receiver holds the result register; the engine then waits with
//   its next result, the command queue fills and in_ready drops.
// reset empties both queues, clears the running total and sets the limit to
//   3000. store contents are not cleared.
// ----------------------------------------------------------------------------
module haptic_sample_fifo_to_rumble #(
  parameter int BUFFER_DEPTH = hsfr_pkg::BUFFER_DEPTH_DEF,
  parameter int CHUNK_LEN    = hsfr_pkg::CHUNK_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hsfr_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hsfr_pkg::FUNC_W-1:0]      func,
  input  logic [hsfr_pkg::SAMPLE_W-1:0]    sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hsfr_pkg::INTENSITY_W-1:0] intensity,
  output logic [hsfr_pkg::TAKEN_W-1:0]     samples_taken,
  output logic [hsfr_pkg::TOTAL_W-1:0]     total_played
);

  logic           cmd_valid;
  logic           cmd_ready;
  hsfr_pkg::cmd_t cmd;

  // front: accept and decode
  hsfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .sample    (sample),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: queue store, chunk reader and scaler
  hsfr_engine #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CHUNK_LEN    (CHUNK_LEN)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .intensity     (intensity),
    .samples_taken (samples_taken),
    .total_played  (total_played)
  );

endmodule

/* design/hsfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_checker
// port level checks on the result channel of the rumble block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsfr_checker #(
  parameter int CHUNK_LEN = hsfr_pkg::CHUNK_LEN_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [hsfr_pkg::INTENSITY_W-1:0] intensity,
  input logic [hsfr_pkg::TAKEN_W-1:0]     samples_taken,
  input logic [hsfr_pkg::TOTAL_W-1:0]     total_played
);

  // a stalled result beat keeps its payload
  `ASSERT_RST(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(intensity) && $stable(samples_taken) && $stable(total_played)), "result beat changed while stalled")

  // never more samples than one chunk
  `ASSERT_RST(a_taken_max, clk, rst, out_valid |-> (samples_taken <= hsfr_pkg::TAKEN_W'(CHUNK_LEN)), "samples_taken above chunk length")

  // an empty chunk is silent
  `ASSERT_RST(a_empty_silent, clk, rst, (out_valid && samples_taken == '0) |-> (intensity == '0), "empty chunk with non-zero intensity")

  // no result beat straight after reset
  `ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid, "result beat right after reset")

endmodule

bind haptic_sample_fifo_to_rumble hsfr_checker #(.CHUNK_LEN(CHUNK_LEN)) u_hsfr_checker (.*);
